/* rtl/prbs15_pkg.sv */
`default_nettype none
package prbs15_pkg;

	localparam int DATA_W    = 8;
	localparam int FRAME_W   = 8;
	localparam int LFSR_W    = 15;
	localparam int SESSION_W = 16;
	localparam int SEED_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int HASH_W    = 32;

	localparam logic [HASH_W-1:0] HASH_SALT      = 32'h6D2B79F5;
	localparam logic [HASH_W-1:0] HASH_MULT      = 32'h045D9F3B;
	localparam logic [HASH_W-1:0] HASH_FRAME_MIX = 32'h9E3779B9;

	// register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] REG_SESSION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_HASH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECT    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_word; // capture a hash-seeded block start word
		logic mul1;      // h = (salt ^ session) * M
		logic mul2;      // h ^= (frame + 1) * mix
		logic mul3;      // h = (h ^ h >> 16) * M
		logic emit_in;   // scramble the word on the input channel
		logic emit_hash; // scramble the captured word with the hash seed
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a word
		logic hash_mode; // seed_from_hash setting
	} dp_stat_t;

	typedef struct packed {
		logic [LFSR_W-1:0] lfsr;
		logic [DATA_W-1:0] key;
	} key_step_t;

	// cut to 15 bits, zero becomes one
	function automatic logic [LFSR_W-1:0] seed_fix(input logic [SEED_W-1:0] s);
		logic [LFSR_W-1:0] m;
		m = s[LFSR_W-1:0];
		return (m == '0) ? LFSR_W'(1) : m;
	endfunction

	// eight generator steps, first key bit lands at the MSB
	function automatic key_step_t key_byte(input logic [LFSR_W-1:0] r_in);
		key_step_t res;
		logic [LFSR_W-1:0] r;
		r = r_in;
		for (int i = 0; i < DATA_W; i++) begin
			res.key[DATA_W-1-i] = r[LFSR_W-1];
			r = {r[LFSR_W-2:0], r[LFSR_W-1] ^ r[LFSR_W-2]};
		end
		res.lfsr = r;
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/prbs15_if.sv */
`default_nettype none
interface prbs15_in_if;
	import prbs15_pkg::*;
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  data_byte;
	logic               block_start;
	logic [FRAME_W-1:0] frame_number;
	logic               block_end;

	modport source (output valid, data_byte, block_start, frame_number, block_end,
		input ready);
	modport sink (input valid, data_byte, block_start, frame_number, block_end,
		output ready);
endinterface

interface prbs15_out_if;
	import prbs15_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;
	logic              out_end;

	modport source (output valid, out_byte, out_end, input ready);
	modport sink (input valid, out_byte, out_end, output ready);
endinterface

interface prbs15_cfg_if;
	import prbs15_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

/* rtl/prbs15_ctrl.sv */
`default_nettype none
module prbs15_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_start,
	input  prbs15_pkg::dp_stat_t  stat,
	output logic                  in_ready,
	output prbs15_pkg::dp_cmd_t   cmd
);
	import prbs15_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && stat.out_free && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_start && stat.hash_mode) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (accept) begin
					if (in_start && stat.hash_mode) begin
						cmd.load_word = 1'b1;
					end else begin
						cmd.emit_in = 1'b1;
					end
				end
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_MUL3: cmd.mul3 = 1'b1;
			ST_EMIT: cmd.emit_hash = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/prbs15_dp.sv */
`default_nettype none
module prbs15_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  prbs15_pkg::dp_cmd_t                 cmd,
	output prbs15_pkg::dp_stat_t                stat,
	input  wire [prbs15_pkg::DATA_W-1:0]        in_data,
	input  wire                                 in_start,
	input  wire [prbs15_pkg::FRAME_W-1:0]       in_frame,
	input  wire                                 in_end,
	input  wire                                 cfg_we,
	input  wire [prbs15_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [prbs15_pkg::CFG_DAT_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [prbs15_pkg::DATA_W-1:0]       out_byte,
	output logic                                out_end
);
	import prbs15_pkg::*;

	logic [SESSION_W-1:0] session_q;
	logic                 hash_mode_q;
	logic [SEED_W-1:0]    direct_q;
	logic [LFSR_W-1:0]    lfsr_q;
	logic [HASH_W-1:0]    h_q;
	logic [DATA_W-1:0]    data_q;
	logic [FRAME_W-1:0]   frame_q;
	logic                 end_q;
	logic [DATA_W-1:0]    out_byte_q;
	logic                 out_end_q;
	logic                 out_valid_q;

	logic [FRAME_W:0]     frame_p1;
	logic [HASH_W-1:0]    h_fold;
	logic [SEED_W-1:0]    hash_low;
	logic [LFSR_W-1:0]    seed;
	key_step_t            ks;
	logic                 emit;

	assign frame_p1 = {1'b0, frame_q} + (FRAME_W+1)'(1);
	assign h_fold   = h_q ^ {16'h0000, h_q[HASH_W-1:16]};
	assign hash_low = h_q[15:0] ^ h_q[HASH_W-1:16];
	assign emit     = cmd.emit_in || cmd.emit_hash;

	always_comb begin
		if (cmd.emit_hash) begin
			seed = seed_fix(hash_low);
		end else if (in_start) begin
			seed = seed_fix(direct_q);
		end else begin
			seed = lfsr_q;
		end
	end

	assign ks = key_byte(seed);

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.hash_mode = hash_mode_q;

	// config and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q   <= '0;
			hash_mode_q <= 1'b1;
			direct_q    <= SEED_W'(1);
			lfsr_q      <= LFSR_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SESSION:   session_q   <= cfg_wdata[SESSION_W-1:0];
					REG_SEED_HASH: hash_mode_q <= cfg_wdata[0];
					REG_DIRECT:    direct_q    <= cfg_wdata[SEED_W-1:0];
					default: ;
				endcase
			end
			if (emit) begin
				lfsr_q      <= ks.lfsr;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			data_q  <= in_data;
			frame_q <= in_frame;
			end_q   <= in_end;
		end
		if (cmd.mul1) begin
			h_q <= (HASH_SALT ^ {16'h0000, session_q}) * HASH_MULT;
		end else if (cmd.mul2) begin
			h_q <= h_q ^ (HASH_W'(frame_p1) * HASH_FRAME_MIX);
		end else if (cmd.mul3) begin
			h_q <= h_fold * HASH_MULT;
		end
		if (cmd.emit_hash) begin
			out_byte_q <= data_q ^ ks.key;
			out_end_q  <= end_q;
		end else if (cmd.emit_in) begin
			out_byte_q <= in_data ^ ks.key;
			out_end_q  <= in_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;

endmodule
`default_nettype wire

/* rtl/prbs15_byte_scrambler.sv */
`default_nettype none
// PRBS15 byte scrambler/descrambler (x^15 + x^14 + 1, key taken from bit 14,
// first key bit at the data MSB). Each word on in_ch gives one word on out_ch,
// out_byte = data_byte ^ key and out_end = block_end. A word with block_start
// reloads the generator first: from direct_seed when seed_from_hash is 0, else
// from a hash of session_number and frame_number. Rate: words without block
// start, and block starts in direct-seed mode, stream at one per clock while
// the output is not stalled. A hash-seeded block start is captured, then the
// hash is three dependent 32-bit multiplies done one per cycle in the datapath
// before the word is scrambled. The output register parts the two sides, so a
// new word is taken in the cycle the previous result is taken. Config writes
// are always ready and apply at the next block start; indexes beyond the
// register list are dropped.
module prbs15_byte_scrambler (
	input  wire           clk,
	input  wire           arst_n,
	prbs15_in_if.sink     in_ch,
	prbs15_out_if.source  out_ch,
	prbs15_cfg_if.sink    cfg
);
	import prbs15_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	assign in_ch.ready = in_ready;
	assign cfg.ready   = 1'b1;

	// sequencer for input acceptance and the hash multiplies
	prbs15_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_start (in_ch.block_start),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// config registers, hash unit, generator, output register
	prbs15_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_ch.data_byte),
		.in_start  (in_ch.block_start),
		.in_frame  (in_ch.frame_number),
		.in_end    (in_ch.block_end),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_wdata (cfg.wdata),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.out_end   (out_ch.out_end)
	);

endmodule
`default_nettype wire
